@@ sv/overwriting_sample_ring_macros.svh @@
// Assertion helpers for the sample ring RTL.
// Every check is sampled on the rising edge of clk and held off during reset.
`ifndef OVERWRITING_SAMPLE_RING_MACROS_SVH
`define OVERWRITING_SAMPLE_RING_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define OSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define OSR_ASSERT_NEVER(lbl, cond, msg) \
	`OSR_ASSERT(lbl, !(cond), msg)

`endif

@@ sv/osr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package osr_pkg;

	// Fixed field widths of the request and result items.
	localparam int DATA_W = 32;
	localparam int OCC_W  = 6;

	// Operation codes carried in the func field.
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DRAIN  = 1'b1;

	// One input request.
	typedef struct packed {
		logic              func;
		logic [DATA_W-1:0] sample_data;
	} osr_in_t;

	// One result item.
	typedef struct packed {
		logic [DATA_W-1:0] out_data;
		logic              out_valid;
		logic              last;
		logic [OCC_W-1:0]  occupancy;
	} osr_out_t;

	// Result load command from the sequencer to the output register.
	typedef struct packed {
		logic             load;
		logic             from_ram;
		logic             valid;
		logic             last;
		logic [OCC_W-1:0] occupancy;
	} osr_emit_t;

endpackage

`default_nettype wire

@@ sv/osr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module osr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ sv/osr_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "overwriting_sample_ring_macros.svh"

module osr_seq #(
	parameter int DEPTH        = 32,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire osr_pkg::osr_in_t         in_item,
	input  wire logic                     out_free,
	output logic                          in_ready,
	output logic                          wr_en,
	output logic      [$clog2(DEPTH)-1:0] wr_addr,
	output logic      [PAYLOAD_BITS-1:0]  wr_data,
	output logic                          rd_en,
	output logic      [$clog2(DEPTH)-1:0] rd_addr,
	output osr_pkg::osr_emit_t            emit
);

	import osr_pkg::*;

	localparam int            AW        = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_EMIT,
		S_END
	} state_t;

	state_t           state_q;
	logic [DEPTH-1:0] valid_q;
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW-1:0]    slot_q;
	logic [AW-1:0]    visit_q;
	logic [OCC_W-1:0] count_q;

	logic             accept;
	logic             is_drain;
	logic             step;
	logic             cnt_dec;
	logic [OCC_W-1:0] cnt_step;
	logic [AW-1:0]    wr_ptr_nxt;
	logic [AW-1:0]    slot_nxt;

	// Handshake and pointer wrap.
	always_comb begin
		in_ready   = (state_q == S_IDLE) && out_free;
		accept     = in_valid && in_ready;
		is_drain   = (in_item.func == FUNC_DRAIN);
		wr_ptr_nxt = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + AW'(1);
		slot_nxt   = (slot_q == LAST_SLOT) ? '0 : slot_q + AW'(1);
		step       = ((state_q == S_WALK) && !valid_q[slot_q])
			|| ((state_q == S_EMIT) && out_free);
	end

	// Shared up/down counter unit: it counts down while walking, up otherwise.
	always_comb begin
		cnt_dec  = (state_q == S_WALK);
		cnt_step = count_q + (cnt_dec ? {OCC_W{1'b1}} : OCC_W'(1));
	end

	// Store ports: inserts write at the write pointer, the walk reads valid slots.
	always_comb begin
		wr_en   = accept && !is_drain;
		wr_addr = wr_ptr_q;
		wr_data = PAYLOAD_BITS'(in_item.sample_data);
		rd_en   = (state_q == S_WALK) && valid_q[slot_q];
		rd_addr = slot_q;
	end

	// Result commands for the output register.
	always_comb begin
		emit = '0;
		unique case (state_q)
			S_IDLE: begin
				emit.load      = accept && !(is_drain && (count_q != '0));
				emit.last      = 1'b1;
				emit.occupancy = (!is_drain && !valid_q[wr_ptr_q]) ? cnt_step : count_q;
			end
			S_WALK: begin
				emit = '0;
			end
			S_EMIT: begin
				emit.load      = out_free;
				emit.from_ram  = 1'b1;
				emit.valid     = 1'b1;
				emit.occupancy = count_q;
			end
			S_END: begin
				emit.load      = out_free;
				emit.last      = 1'b1;
				emit.occupancy = count_q;
			end
			default: begin
				emit = '0;
			end
		endcase
	end

	// Sequencer, valid marks, pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			slot_q   <= '0;
			visit_q  <= '0;
			count_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && !is_drain) begin
						valid_q[wr_ptr_q] <= 1'b1;
						if (!valid_q[wr_ptr_q]) begin
							count_q <= cnt_step;
						end
						wr_ptr_q <= wr_ptr_nxt;
					end else if (accept && (count_q != '0)) begin
						slot_q  <= rd_ptr_q;
						visit_q <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (valid_q[slot_q]) begin
						valid_q[slot_q] <= 1'b0;
						count_q         <= cnt_step;
						state_q         <= S_EMIT;
					end
				end
				S_EMIT: begin
					// On the last visit the slot step below moves on to the end marker.
					if (out_free && (visit_q != LAST_SLOT)) begin
						state_q <= S_WALK;
					end
				end
				S_END: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Move to the next slot, or finish after a full lap.
			if (step) begin
				if (visit_q == LAST_SLOT) begin
					rd_ptr_q <= slot_nxt;
					state_q  <= S_END;
				end else begin
					slot_q  <= slot_nxt;
					visit_q <= visit_q + AW'(1);
				end
			end
		end
	end

	`OSR_ASSERT(a_count_matches_marks, count_q == OCC_W'($countones(valid_q)), "occupancy count differs from valid marks")
	`OSR_ASSERT(a_read_only_valid, rd_en |-> valid_q[rd_addr], "store read at a slot not marked valid")
	`OSR_ASSERT(a_load_needs_room, emit.load |-> out_free, "result loaded over a pending result")
	`OSR_ASSERT(a_read_ptr_lap, $stable(rd_ptr_q), "drain did not end on its starting slot")
	`OSR_ASSERT_NEVER(a_no_read_and_write, rd_en && wr_en, "store read and written in one cycle")

endmodule

`default_nettype wire

@@ sv/overwriting_sample_ring.sv @@
// Overwriting sample ring: a circular capture store of DEPTH entries with valid marks.
// Requests enter on in_valid/in_ready with in_item (func, sample_data); results leave
// on out_valid/out_ready with out_item (out_data, out_valid, last, occupancy).
// An insert writes at the write pointer, overwriting the oldest slot when full, and
// gives one result (last set, occupancy after the insert) in the cycle after acceptance.
// Inserts are taken one per cycle while results are taken as fast.
// A drain walks all DEPTH slots from the read pointer, one empty slot per cycle through the
// single read port of the entry store; each valid entry also waits for its registered read
// and is emitted and cleared. A final marker with last set ends the run; an empty store
// answers with the marker alone in the cycle after acceptance. No request is taken
// until the drain has ended.
// Results sit in one output register; in_ready falls while it is full and not being
// taken, and a stalled drain simply waits at its current slot.
// Reset clears valid marks, pointers and occupancy at once; the entry store itself is
// not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module overwriting_sample_ring #(
	parameter int DEPTH        = 32,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire osr_pkg::osr_in_t  in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output osr_pkg::osr_out_t      out_item
);

	import osr_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic                    out_free;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [PAYLOAD_BITS-1:0] wr_data;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic [PAYLOAD_BITS-1:0] rd_data;
	osr_emit_t               emit;
	logic                    out_valid_q;
	osr_out_t                out_item_q;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	osr_seq #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.out_free (out_free),
		.in_ready (in_ready),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.emit     (emit)
	);

	osr_ram #(
		.WIDTH (PAYLOAD_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Output register: the valid flag is control state, the item is payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_item_q.out_data  <= emit.from_ram ? DATA_W'(rd_data) : '0;
			out_item_q.out_valid <= emit.valid;
			out_item_q.last      <= emit.last;
			out_item_q.occupancy <= emit.occupancy;
		end
	end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import osr_pkg::*;

	localparam int DEPTH        = 32;
	localparam int PAYLOAD_BITS = 32;
	localparam logic [63:0] PAYLOAD_MASK = {64{1'b1}} >> (64 - PAYLOAD_BITS);

	// A silent stretch this long means the ring has hung.
	localparam int STALL_LIMIT  = 2000;
	// Long receiver hold-off that fills the output register and stalls requests.
	localparam int HOLD_CYCLES  = 150;
	// A full drain with every slot valid, plus margin.
	localparam int DRAIN_SETTLE = 2 * DEPTH + 16;
	localparam int PRINT_LIMIT  = 50;

	// One line of the directed script: a run of identical requests, the last of which
	// may carry its final result written out by hand.
	typedef struct {
		logic              func;
		logic [DATA_W-1:0] base;
		int                copies;
		bit                typed;
		osr_out_t          final_result;
	} script_row_t;

	localparam int SCRIPT_ROWS = 15;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	osr_in_t  in_item   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	osr_out_t out_item;

	// Shadow copy of the ring.
	logic [DATA_W-1:0] ring_data [DEPTH];
	bit                ring_mark [DEPTH];
	int                wr_slot    = 0;
	int                rd_slot    = 0;
	int                live_count = 0;

	osr_out_t ring_results_due [$];

	int  mismatch_count = 0;
	int  send_idle_pct  = 0;
	int  recv_idle_pct  = 0;
	bit  hold_pending   = 1'b0;
	int  quiet_cycles   = 0;

	script_row_t ring_script [SCRIPT_ROWS] = '{
		// Drain straight after reset: the store is empty, only the end marker comes.
		'{FUNC_DRAIN,  32'h0000_0000, 1,  1'b1, '{32'h0, 1'b0, 1'b1, 6'd0}},
		'{FUNC_INSERT, 32'h0000_0000, 1,  1'b1, '{32'h0, 1'b0, 1'b1, 6'd1}},
		'{FUNC_INSERT, 32'hFFFF_FFFF, 1,  1'b1, '{32'h0, 1'b0, 1'b1, 6'd2}},
		'{FUNC_INSERT, 32'hAAAA_AAAA, 1,  1'b0, '{32'h0, 1'b0, 1'b0, 6'd0}},
		'{FUNC_INSERT, 32'h5555_5555, 1,  1'b0, '{32'h0, 1'b0, 1'b0, 6'd0}},
		'{FUNC_DRAIN,  32'h0000_0000, 1,  1'b1, '{32'h0, 1'b0, 1'b1, 6'd0}},
		'{FUNC_DRAIN,  32'hFFFF_FFFF, 1,  1'b1, '{32'h0, 1'b0, 1'b1, 6'd0}},
		// Fill the ring to the brim, then keep writing so that old entries are lost.
		'{FUNC_INSERT, 32'h8000_0001, 31, 1'b1, '{32'h0, 1'b0, 1'b1, 6'd31}},
		'{FUNC_INSERT, 32'h7FFF_FFFE, 1,  1'b1, '{32'h0, 1'b0, 1'b1, 6'd32}},
		'{FUNC_INSERT, 32'hC0DE_0000, 9,  1'b1, '{32'h0, 1'b0, 1'b1, 6'd32}},
		'{FUNC_DRAIN,  32'h0000_0000, 1,  1'b1, '{32'h0, 1'b0, 1'b1, 6'd0}},
		// A short run that starts mid ring, so the drain sees entries past the wrap.
		'{FUNC_INSERT, 32'h1234_5678, 27, 1'b0, '{32'h0, 1'b0, 1'b0, 6'd0}},
		'{FUNC_DRAIN,  32'h0000_0000, 1,  1'b0, '{32'h0, 1'b0, 1'b0, 6'd0}},
		'{FUNC_INSERT, 32'hFFFF_FFFF, 1,  1'b0, '{32'h0, 1'b0, 1'b0, 6'd0}},
		'{FUNC_DRAIN,  32'h0000_0000, 1,  1'b0, '{32'h0, 1'b0, 1'b0, 6'd0}}
	};

	overwriting_sample_ring #(
		.DEPTH       (DEPTH),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Work out every result one request causes and queue them in order.
	function automatic void predict_ring(input osr_in_t req);
		int       slot;
		int       visit;
		osr_out_t res;
		if (req.func == FUNC_INSERT) begin
			slot = wr_slot;
			ring_data[slot] = DATA_W'(req.sample_data & PAYLOAD_MASK);
			if (!ring_mark[slot]) begin
				ring_mark[slot] = 1'b1;
				if (live_count < DEPTH)
					live_count++;
			end
			wr_slot = (slot + 1) % DEPTH;
		end else if (live_count != 0) begin
			slot = rd_slot;
			for (visit = 0; visit < DEPTH; visit++) begin
				if (ring_mark[slot]) begin
					ring_mark[slot] = 1'b0;
					if (live_count > 0)
						live_count--;
					res.out_data  = ring_data[slot];
					res.out_valid = 1'b1;
					res.last      = 1'b0;
					res.occupancy = OCC_W'(live_count);
					ring_results_due.push_back(res);
				end
				slot = (slot + 1) % DEPTH;
			end
			rd_slot = slot;
		end
		res.out_data  = '0;
		res.out_valid = 1'b0;
		res.last      = 1'b1;
		res.occupancy = OCC_W'(live_count);
		ring_results_due.push_back(res);
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns: mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Offer one request, hold it until taken, then record what it should cause.
	// A hand-written final result, where given, stands in for the predicted one.
	task automatic send_request(input osr_in_t req, input bit typed, input osr_out_t final_result);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_item  <= req;
		do @(posedge clk); while (!in_ready);
		predict_ring(req);
		if (typed) begin
			void'(ring_results_due.pop_back());
			ring_results_due.push_back(final_result);
		end
	endtask

	// Mostly bursts of inserts closed by a drain; now and then a second drain on an
	// empty ring.
	task automatic run_random(input int items);
		int       sent;
		int       burst;
		int       k;
		osr_in_t  req;
		osr_out_t unused;
		sent   = 0;
		unused = '0;
		while (sent < items) begin
			burst = $urandom_range(45, 1);
			for (k = 0; k < burst && sent < items; k++) begin
				req.func = FUNC_INSERT;
				case ($urandom_range(7))
					0: req.sample_data = '0;
					1: req.sample_data = '1;
					default: req.sample_data = $urandom;
				endcase
				send_request(req, 1'b0, unused);
				sent++;
			end
			if (sent < items) begin
				req.func        = FUNC_DRAIN;
				req.sample_data = $urandom;
				send_request(req, 1'b0, unused);
				sent++;
				if ($urandom_range(5) == 0 && sent < items) begin
					send_request(req, 1'b0, unused);
					sent++;
				end
			end
		end
	endtask

	// Result side: check each accepted result against the oldest expectation and
	// choose the ready level for the next cycle.
	initial begin
		int       hold_left;
		osr_out_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (ring_results_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", out_item));
				end else begin
					want = ring_results_due.pop_front();
					if (out_item.out_data !== want.out_data)
						report_mismatch($sformatf("out_data %h, want %h",
							out_item.out_data, want.out_data));
					if (out_item.out_valid !== want.out_valid)
						report_mismatch($sformatf("out_valid %b, want %b",
							out_item.out_valid, want.out_valid));
					if (out_item.last !== want.last)
						report_mismatch($sformatf("last %b, want %b",
							out_item.last, want.last));
					if (out_item.occupancy !== want.occupancy)
						report_mismatch($sformatf("occupancy %0d, want %0d",
							out_item.occupancy, want.occupancy));
				end
			end
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: any cycle without a handshake on either side counts towards the limit.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus: reset, directed script, then three randomised phases.
	initial begin
		int      r;
		int      k;
		osr_in_t req;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 79;
		for (r = 0; r < SCRIPT_ROWS; r++) begin
			for (k = 0; k < ring_script[r].copies; k++) begin
				req.func        = ring_script[r].func;
				req.sample_data = ring_script[r].base + DATA_W'(k);
				send_request(req, ring_script[r].typed && k == ring_script[r].copies - 1,
					ring_script[r].final_result);
			end
		end

		run_random(77);

		send_idle_pct = 79;
		recv_idle_pct = 26;
		run_random(77);

		// No idling; the receiver first holds off while inserts keep coming.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_pending  = 1'b1;
		run_random(77);

		in_valid <= 1'b0;
		while (ring_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SETTLE) @(posedge clk);

		if (mismatch_count == 0 && ring_results_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/osr_pkg.sv
sv/osr_ram.sv
sv/osr_seq.sv
sv/overwriting_sample_ring.sv
verif/tb.sv
